@@ rtl/rtcmf_pkg.sv @@
// Package for the RTCM message fragmenter: item types and fixed field widths.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rtcmf_pkg;

	localparam int BYTE_W       = 8;
	localparam int BLOB_LEN_W   = 16;
	localparam int MSG_LEN_W    = 8;
	localparam int FLAGS_W      = 8;
	localparam int SEQ_ID_W     = 5;
	localparam int FRAG_ID_W    = 2;

	typedef struct packed {
		logic [BYTE_W-1:0]     byte_value;
		logic                  first_of_blob;
		logic [BLOB_LEN_W-1:0] blob_length;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    out_byte;
		logic [MSG_LEN_W-1:0] message_length;
		logic [FLAGS_W-1:0]   flags;
		logic                 first_of_message;
		logic                 last_of_message;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/rtcmf_if.sv @@
// Valid/ready channel interfaces for the fragmenter's input and result items.
// Depends on rtcmf_pkg for the payload types.
`default_nettype none

interface rtcmf_in_if;
	import rtcmf_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface rtcmf_out_if;
	import rtcmf_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/rtcm_message_fragmenter_core.sv @@
// Top level of the RTCM message fragmenter: input register, tagger, result register.
// Depends on rtcmf_pkg, rtcmf_if.sv and rtcmf_tagger.
//
// Usage: bytes of a correction blob enter on ingress, one byte per item, with
// first_of_blob set on the first byte and blob_length valid on that byte. Each
// byte leaves on egress tagged with its message length, flags (fragmented bit,
// fragment id, sequence id) and first/last-of-message marks. A blob is cut into
// sequences of up to MESSAGE_BYTES * MAX_FRAGMENTS bytes, each cut into messages
// of up to MESSAGE_BYTES bytes.
// Path: an accepted item passes through the input register, then the result
// register, before it is offered on egress. Throughput: one item per cycle
// while egress.ready is high; the counters advance by one byte per cycle
// while items move into the result register.
// Stall: when egress.ready is low the result register holds, the input
// register fills behind it, and ingress.ready drops only when both are full.
// Reset: arst_n clears both pipeline valids and all counters; the first item
// after reset opens a fresh blob with sequence id zero.
`default_nettype none

module rtcm_message_fragmenter_core #(
	parameter int MESSAGE_BYTES = 180,
	parameter int MAX_FRAGMENTS = 4,
	parameter int LENGTH_BITS   = 16
) (
	input wire          clk,
	input wire          arst_n,
	rtcmf_in_if.sink    ingress,
	rtcmf_out_if.source egress
);
	import rtcmf_pkg::*;

	logic      valid_s1, valid_s2;
	in_item_t  item_s1;
	out_item_t result_s2;
	out_item_t result;
	logic      adv_s1;

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1        = !valid_s2 || egress.ready;
	assign ingress.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	// payload register: capture on every accepted item
	always_ff @(posedge clk) begin
		if (ingress.valid && ingress.ready) begin
			item_s1 <= ingress.payload;
		end
	end

	// counters advance exactly once per item, when it moves into stage 2
	rtcmf_tagger #(
		.MESSAGE_BYTES (MESSAGE_BYTES),
		.MAX_FRAGMENTS (MAX_FRAGMENTS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_tagger (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv_s1),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			result_s2 <= result;
		end
	end

	assign egress.valid   = valid_s2;
	assign egress.payload = result_s2;

	// an accepted item always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ingress.valid && ingress.ready |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// a waiting result never blocks intake while stage 1 is empty
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> ingress.ready)
		else $error("intake stalled with stage 1 empty");

	// every delivered byte belongs to a message of nonzero length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.message_length != '0)
		else $error("zero message length on result");

	// a byte marked both first and last belongs to a one-byte message
	a_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.first_of_message && result_s2.last_of_message
		|-> result_s2.message_length == MSG_LEN_W'(1))
		else $error("first and last marks on a longer message");

	// unfragmented messages carry no fragment id
	a_frag_id: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.flags[0] |-> result_s2.flags[2:1] == 2'b00)
		else $error("fragment id set on unfragmented message");

endmodule

`default_nettype wire

@@ rtl/rtcmf_tagger.sv @@
// Sequence/message counters of the fragmenter and the tagging logic of one byte.
// Depends on rtcmf_pkg; instantiated by rtcm_message_fragmenter_core.
`default_nettype none

module rtcmf_tagger #(
	parameter int MESSAGE_BYTES = 180,
	parameter int MAX_FRAGMENTS = 4,
	parameter int LENGTH_BITS   = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  rtcmf_pkg::in_item_t  item,
	output rtcmf_pkg::out_item_t result
);
	import rtcmf_pkg::*;

	localparam int CAP   = MESSAGE_BYTES * MAX_FRAGMENTS;
	localparam int SEQ_W = $clog2(CAP + 1);
	localparam int CMP_W = (LENGTH_BITS > SEQ_W) ? LENGTH_BITS : SEQ_W;

	logic [LENGTH_BITS-1:0] blob_rem_q;
	logic [SEQ_W-1:0]       seq_rem_q;
	logic [MSG_LEN_W-1:0]   msg_rem_q;
	logic [MSG_LEN_W-1:0]   cur_len_q;
	logic                   frag_mode_q;
	logic [FRAG_ID_W-1:0]   frag_num_q;
	logic [SEQ_ID_W-1:0]    seq_num_q;

	logic [LENGTH_BITS-1:0] blen;
	logic [LENGTH_BITS-1:0] blob_a, blob_d;
	logic [SEQ_W-1:0]       seq_rem_a, seq_rem_b, seq_rem_d, slen;
	logic [MSG_LEN_W-1:0]   msg_rem_a, msg_rem_b, msg_rem_c, msg_rem_d, mlen;
	logic [MSG_LEN_W-1:0]   cur_len_c;
	logic                   frag_mode_b;
	logic [FRAG_ID_W-1:0]   frag_num_b, frag_num_d;
	logic [SEQ_ID_W-1:0]    seq_num_a, seq_num_d;
	logic [CMP_W-1:0]       blob_ext;
	logic                   first_msg, last_msg;

	generate
		if (LENGTH_BITS <= BLOB_LEN_W) begin : g_len_trunc
			assign blen = item.blob_length[LENGTH_BITS-1:0];
		end else begin : g_len_ext
			assign blen = {{(LENGTH_BITS-BLOB_LEN_W){1'b0}}, item.blob_length};
		end
	endgenerate

	always_comb begin
		// open a blob: explicit first byte, or a stray byte with no blob open
		seq_num_a = seq_num_q;
		blob_a    = blob_rem_q;
		seq_rem_a = seq_rem_q;
		msg_rem_a = msg_rem_q;
		if (item.first_of_blob) begin
			if (seq_rem_q != '0)
				seq_num_a = seq_num_q + SEQ_ID_W'(1);
			blob_a    = (blen == '0) ? LENGTH_BITS'(1) : blen;
			seq_rem_a = '0;
			msg_rem_a = '0;
		end else if (blob_rem_q == '0) begin
			blob_a    = LENGTH_BITS'(1);
			seq_rem_a = '0;
			msg_rem_a = '0;
		end

		// open a sequence
		blob_ext    = CMP_W'(blob_a);
		slen        = (blob_ext < CMP_W'(CAP)) ? SEQ_W'(blob_ext) : SEQ_W'(CAP);
		seq_rem_b   = seq_rem_a;
		frag_mode_b = frag_mode_q;
		frag_num_b  = frag_num_q;
		msg_rem_b   = msg_rem_a;
		if (seq_rem_a == '0) begin
			seq_rem_b   = slen;
			frag_mode_b = (slen >= SEQ_W'(MESSAGE_BYTES));
			frag_num_b  = '0;
			msg_rem_b   = '0;
		end

		// open a message
		mlen      = (seq_rem_b < SEQ_W'(MESSAGE_BYTES)) ? MSG_LEN_W'(seq_rem_b)
			: MSG_LEN_W'(MESSAGE_BYTES);
		first_msg = (msg_rem_b == '0);
		cur_len_c = first_msg ? mlen : cur_len_q;
		msg_rem_c = first_msg ? mlen : msg_rem_b;

		// consume the byte
		msg_rem_d = msg_rem_c - MSG_LEN_W'(1);
		seq_rem_d = seq_rem_b - SEQ_W'(1);
		blob_d    = blob_a - LENGTH_BITS'(1);
		last_msg  = (msg_rem_d == '0);

		frag_num_d = last_msg ? frag_num_b + FRAG_ID_W'(1) : frag_num_b;
		seq_num_d  = (seq_rem_d == '0) ? seq_num_a + SEQ_ID_W'(1) : seq_num_a;

		result.out_byte         = item.byte_value;
		result.message_length   = cur_len_c;
		result.flags            = frag_mode_b ? {seq_num_a, frag_num_b, 1'b1}
			: {seq_num_a, 3'b000};
		result.first_of_message = first_msg;
		result.last_of_message  = last_msg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_rem_q  <= '0;
			seq_rem_q   <= '0;
			msg_rem_q   <= '0;
			cur_len_q   <= '0;
			frag_mode_q <= 1'b0;
			frag_num_q  <= '0;
			seq_num_q   <= '0;
		end else if (step) begin
			blob_rem_q  <= blob_d;
			seq_rem_q   <= seq_rem_d;
			msg_rem_q   <= msg_rem_d;
			cur_len_q   <= cur_len_c;
			frag_mode_q <= frag_mode_b;
			frag_num_q  <= frag_num_d;
			seq_num_q   <= seq_num_d;
		end
	end

endmodule

`default_nettype wire
